[rtl/core/flmxh_pkg.sv]
package flmxh_pkg;

	localparam logic [15:0] MIX_KEY = 16'hca95;
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [4:0] FINAL_MIXES = 5'd24;

	localparam logic [63:0] LANE_INIT [8] = '{
		64'hc05bbd6b47c57574, 64'hf83c1e9e4a934534,
		64'ha224e4507e645d91, 64'he7a9131a4b842813,
		64'h58f082e3580f347e, 64'hceb5795349196aff,
		64'hb549200b5168588f, 64'hfd5c07200540ada5
	};

	localparam logic CFG_SEED_LOW = 1'b0;
	localparam logic CFG_SEED_HIGH = 1'b1;

	typedef struct packed {
		logic        last_word;
		logic [3:0]  valid_bytes;
		logic [63:0] data_word;
	} in_item_t;

	typedef struct packed {
		logic [63:0] hash_high;
		logic [63:0] hash_low;
	} out_item_t;

endpackage

[rtl/core/four_lane_multiply_xor_hash.sv]
// channel | signals                              | accepted when
// in      | in_valid, in_ready, in_data          | in_valid && in_ready
// out     | out_valid, out_ready, out_data       | out_valid && out_ready
// cfg     | cfg_we, cfg_index, cfg_data          | cfg_we
// A word that leaves its 64-byte block partial is taken in ST_IDLE alone; completing
// a block adds an absorb (one lane mix per cycle through the shared mix unit).
// Last word: padding writes one 8-byte word a cycle (up to 9, with an absorb
// for each filled block), then 4x24 lane mixes and 4 fold mixes, one per cycle.
// Result waits in the out register.
// Reset (arst_n low) loads lanes from the constants with a zero seed.
module four_lane_multiply_xor_hash
	import flmxh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);

	typedef enum logic [2:0] {ST_IDLE, ST_ABSORB, ST_PAD, ST_FINAL, ST_FOLD, ST_OUT} state_t;

	state_t       state_q;
	logic [63:0]  seed_lo_q, seed_hi_q;
	logic [63:0]  lane_q [8];
	logic [63:0]  blk_q [8];
	logic [63:0]  spill_q;
	logic [5:0]   fill_q;
	logic [63:0]  msg_q;
	logic [63:0]  len_q;
	logic         fin_q;
	logic         pad_mark_q;
	logic         len_done_q;
	logic [1:0]   lane_q_idx;
	logic [4:0]   rnd_q;
	logic [127:0] h_q;
	logic [127:0] mix_in, mix_out;

	logic [3:0]   nb;
	logic [6:0]   sum;
	logic [127:0] w_cat;
	logic [63:0]  pad_word;
	logic [2:0]   fw;
	logic [2:0]   fb;

	flmxh_mix u_mix (.x(mix_in), .y(mix_out));

	assign nb = (in_data.valid_bytes > 4'd8) ? 4'd8 : in_data.valid_bytes;
	assign fw = fill_q[5:3];
	assign fb = fill_q[2:0];
	assign in_ready = (state_q == ST_IDLE);

	// bytes placed at the fill offset, spill goes to the next word
	assign w_cat = {64'd0, in_data.data_word & ((nb == 4'd8) ? {64{1'b1}} :
		((64'd1 << {nb[2:0], 3'd0}) - 64'd1))} << {fb, 3'd0};

	always_comb begin
		sum = {1'b0, fill_q} + {3'd0, nb};
		pad_word = 64'd0;
		if (pad_mark_q) pad_word = 64'(PAD_MARK);
		else if (fill_q == LEN_POS) pad_word = len_q;
		mix_in = {lane_q[{lane_q_idx, 1'b1}], lane_q[{lane_q_idx, 1'b0}]};
		if (state_q == ST_ABSORB)
			mix_in = mix_in ^ {blk_q[{lane_q_idx, 1'b1}], blk_q[{lane_q_idx, 1'b0}]};
		if (state_q == ST_FOLD)
			mix_in = h_q ^ mix_in;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			if (fb == 3'd0) blk_q[fw] <= w_cat[63:0];
			else begin
				blk_q[fw] <= (blk_q[fw] & ((64'd1 << {fb, 3'd0}) - 64'd1)) | w_cat[63:0];
				if (sum[6:3] != {1'b0, fw}) begin
					// spill into the next block waits until lane 0 has read word 0
					if (sum[6]) spill_q <= w_cat[127:64];
					else blk_q[3'(fw + 3'd1)] <= w_cat[127:64];
				end
			end
		end else if (state_q == ST_PAD) begin
			// pad mark sits at byte fb of word fw; zeros above it
			if (pad_mark_q && fb != 3'd0)
				blk_q[fw] <= (blk_q[fw] & ((64'd1 << {fb, 3'd0}) - 64'd1)) |
					(64'(PAD_MARK) << {fb, 3'd0});
			else blk_q[fw] <= pad_word;
		end else if (state_q == ST_ABSORB && lane_q_idx == 2'd0) begin
			blk_q[0] <= spill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seed_lo_q <= '0;
			seed_hi_q <= '0;
			for (int i = 0; i < 8; i++) lane_q[i] <= LANE_INIT[i];
			fill_q <= '0;
			msg_q <= '0;
			len_q <= '0;
			fin_q <= 1'b0;
			pad_mark_q <= 1'b0;
			len_done_q <= 1'b0;
			lane_q_idx <= '0;
			rnd_q <= '0;
			h_q <= '0;
			out_valid <= 1'b0;
			out_data <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_SEED_LOW) seed_lo_q <= cfg_data;
				else seed_hi_q <= cfg_data;
				if (msg_q == 64'd0)
					for (int i = 0; i < 8; i++)
						lane_q[i] <= LANE_INIT[i] ^ ((i % 2 == 1) ?
							((cfg_index == CFG_SEED_HIGH) ? cfg_data : seed_hi_q) :
							((cfg_index == CFG_SEED_LOW) ? cfg_data : seed_lo_q));
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						msg_q <= msg_q + 64'(nb);
						len_q <= msg_q + 64'(nb);
						fin_q <= in_data.last_word;
						pad_mark_q <= 1'b1;
						len_done_q <= 1'b0;
						fill_q <= sum[5:0];
						lane_q_idx <= '0;
						if (sum[6]) state_q <= ST_ABSORB;
						else if (in_data.last_word) state_q <= ST_PAD;
					end
				end
				ST_ABSORB: begin
					lane_q[{lane_q_idx, 1'b0}] <= mix_out[63:0];
					lane_q[{lane_q_idx, 1'b1}] <= mix_out[127:64];
					lane_q_idx <= lane_q_idx + 2'd1;
					if (lane_q_idx == 2'd3) begin
						if (fin_q) begin
							state_q <= ST_PAD;
							if (len_done_q) begin
								state_q <= ST_FINAL;
								rnd_q <= '0;
							end
						end else state_q <= ST_IDLE;
					end
				end
				ST_PAD: begin
					pad_mark_q <= 1'b0;
					fill_q <= {fw + 3'd1, 3'd0};
					if (fw == 3'd7) begin
						// length lands in word 7 only once the mark is already placed
						len_done_q <= !pad_mark_q;
						state_q <= ST_ABSORB;
						lane_q_idx <= '0;
					end
				end
				ST_FINAL: begin
					lane_q[{lane_q_idx, 1'b0}] <= mix_out[63:0];
					lane_q[{lane_q_idx, 1'b1}] <= mix_out[127:64];
					rnd_q <= rnd_q + 5'd1;
					if (rnd_q == FINAL_MIXES - 5'd1) begin
						rnd_q <= '0;
						lane_q_idx <= lane_q_idx + 2'd1;
						if (lane_q_idx == 2'd3) begin
							state_q <= ST_FOLD;
							h_q <= '0;
						end
					end
				end
				ST_FOLD: begin
					h_q <= mix_out;
					lane_q_idx <= lane_q_idx + 2'd1;
					if (lane_q_idx == 2'd3) begin
						out_valid <= 1'b1;
						out_data <= {mix_out[127:64], mix_out[63:0]};
						state_q <= ST_OUT;
						for (int i = 0; i < 8; i++)
							lane_q[i] <= LANE_INIT[i] ^ ((i % 2 == 1) ? seed_hi_q : seed_lo_q);
						fill_q <= '0;
						msg_q <= '0;
						fin_q <= 1'b0;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/flmxh_mix.sv]
// One 128-bit mix, combinational: sixteen 16x16 multiplies, registered by the caller.
module flmxh_mix
	import flmxh_pkg::*;
(
	input  logic [127:0] x,
	output logic [127:0] y
);

	logic [127:0] a;
	logic [15:0]  ap [8];
	logic [31:0]  lo_p [8];
	logic signed [31:0] hi_p [8];

	assign a = x ^ {8{MIX_KEY}};

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			ap[i] = a[16*i +: 16];
		end
		for (int i = 0; i < 8; i++) begin
			lo_p[i] = 32'(ap[i]) * 32'(MIX_KEY);
			hi_p[i] = 32'($signed(ap[(i + 1) % 8])) * 32'($signed(MIX_KEY));
			y[16*i +: 16] = lo_p[i][15:0] ^ hi_p[i][31:16];
		end
	end

endmodule
